// ----- rtl/cpb_pkg.sv -----
// shared types and constants of the clipped premultiplied blitter
package cpb_pkg;

  localparam int PIX_W      = 32;
  localparam int IDX_W      = 25;
  localparam int COORD_W    = 13;
  localparam int PITCH_W    = 14;
  localparam int CFG_DATA_W = 14;

  localparam logic [7:0] OPAQUE_ALPHA = 8'd250;
  localparam logic [7:0] CHAN_MAX     = 8'hFF;
  localparam int         ALPHA_LSB    = 24;

  // register reset values
  localparam logic signed [COORD_W-1:0] DEST_X_RST      = 13'sd0;
  localparam logic signed [COORD_W-1:0] DEST_Y_RST      = 13'sd0;
  localparam logic [COORD_W-1:0]        RECT_WIDTH_RST  = 13'd1;
  localparam logic [COORD_W-1:0]        RECT_HEIGHT_RST = 13'd1;
  localparam logic [COORD_W-1:0]        FB_WIDTH_RST    = 13'd1024;
  localparam logic [COORD_W-1:0]        FB_HEIGHT_RST   = 13'd768;
  localparam logic [PITCH_W-1:0]        FB_PITCH_RST    = 14'd1024;
  localparam logic [PITCH_W-1:0]        STRIDE_RST      = 14'd1024;

  typedef enum logic [2:0] {
    REG_DEST_X,
    REG_DEST_Y,
    REG_RECT_WIDTH,
    REG_RECT_HEIGHT,
    REG_FB_WIDTH,
    REG_FB_HEIGHT,
    REG_FB_PITCH,
    REG_SOURCE_STRIDE
  } reg_index_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] dest_x;
    logic signed [COORD_W-1:0] dest_y;
    logic [COORD_W-1:0]        rect_width;
    logic [COORD_W-1:0]        rect_height;
    logic [COORD_W-1:0]        fb_width;
    logic [COORD_W-1:0]        fb_height;
    logic [PITCH_W-1:0]        fb_pitch;
    logic [PITCH_W-1:0]        source_stride;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] src_pixel;
    logic [PIX_W-1:0] dst_pixel;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0] fb_index;
    logic [PIX_W-1:0] out_pixel;
    logic             write_enable;
    logic [IDX_W-1:0] source_offset;
    logic             last;
  } result_t;

  // placement of one pixel
  typedef struct packed {
    logic             visible;
    logic [IDX_W-1:0] fb_index;
    logic [IDX_W-1:0] source_offset;
    logic             last;
  } pos_t;

endpackage

// ----- rtl/cpb_stream_if.sv -----
// valid/ready stream channel with a typed payload
interface cpb_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/clipped_premultiplied_blit.sv -----
// top level of the clipped premultiplied-alpha blitter
//
// The block takes the source rectangle's pixels in raster order, one request
// per pixel carrying the source pixel and the framebuffer pixel at its target,
// and returns one result per request: the framebuffer index, the pixel to write,
// a write enable, the source offset and a last flag on the rectangle's final
// pixel. Row and column counters place each request at (dest_x + col,
// dest_y + row); anything outside 0..fb_width-1 by 0..fb_height-1 comes back
// with index 0, pixel 0 and no write. Alpha of 250 or more copies the source,
// alpha 0 returns the framebuffer pixel without a write, and any other alpha
// blends each channel as src + dst*(255-a)/255 with carries left to spill into
// the next byte. A request, taken every clock unless the result side stalls,
// passes through an input register, then the result register, with the index
// multipliers and the blend between them. Stalls back up through the two
// stages, and a request is still taken while a finished result waits if the
// input register is empty. Any configuration write restarts the counters at
// the top-left of the rectangle; write only while no request is in flight.
// rect_width and rect_height saturate to 1..MAX_DIM on write.
module clipped_premultiplied_blit #(
  parameter int MAX_DIM = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  cpb_stream_if.sink                     item,
  cpb_stream_if.source                   result,
  input  logic                           write_en,
  input  cpb_pkg::reg_index_t            reg_index,
  input  logic [cpb_pkg::CFG_DATA_W-1:0] write_data
);
  import cpb_pkg::*;

  localparam int CNT_W = $clog2(MAX_DIM);
  localparam int CMP_W = ((CNT_W + 1) > COORD_W) ? (CNT_W + 1) : COORD_W;

  cfg_t cfg;

  // raster counters
  logic [CNT_W-1:0] row_count;
  logic [CNT_W-1:0] col_count;
  logic [CNT_W-1:0] row_count_next;
  logic [CNT_W-1:0] col_count_next;
  logic             col_end;
  logic             row_end;

  // input register
  logic             s1_valid;
  logic [PIX_W-1:0] s1_src;
  logic [PIX_W-1:0] s1_dst;
  logic [CNT_W-1:0] s1_row;
  logic [CNT_W-1:0] s1_col;

  // result register
  logic    out_valid;
  result_t out_data;

  logic       item_take;
  logic       out_open;
  logic       s1_advance;
  pos_t       pos;
  logic [PIX_W-1:0] pix;
  logic       pix_we;

  cpb_config #(
    .MAX_DIM(MAX_DIM)
  ) u_config (
    .clk       (clk),
    .rst       (rst),
    .write_en  (write_en),
    .reg_index (reg_index),
    .write_data(write_data),
    .cfg       (cfg)
  );

  // handshake: the result register frees when empty or being taken
  assign out_open   = !out_valid || result.ready;
  assign s1_advance = s1_valid && out_open;
  assign item.ready = !s1_valid || out_open;
  assign item_take  = item.valid && item.ready;

  // counter stepping
  assign col_end = CMP_W'(col_count) + CMP_W'(1) >= CMP_W'(cfg.rect_width);
  assign row_end = CMP_W'(row_count) + CMP_W'(1) >= CMP_W'(cfg.rect_height);

  always_comb begin
    row_count_next = row_count;
    col_count_next = col_count;
    if (write_en) begin
      // a new rectangle starts after any register write
      row_count_next = '0;
      col_count_next = '0;
    end else if (item_take) begin
      if (col_end) begin
        col_count_next = '0;
        row_count_next = row_end ? '0 : row_count + CNT_W'(1);
      end else begin
        col_count_next = col_count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else begin
      row_count <= row_count_next;
      col_count <= col_count_next;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_take) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      s1_src <= item.data.src_pixel;
      s1_dst <= item.data.dst_pixel;
      s1_row <= row_count;
      s1_col <= col_count;
    end
  end

  cpb_position #(
    .CNT_W(CNT_W)
  ) u_position (
    .cfg(cfg),
    .row(s1_row),
    .col(s1_col),
    .pos(pos)
  );

  cpb_blend u_blend (
    .src_pixel   (s1_src),
    .dst_pixel   (s1_dst),
    .visible     (pos.visible),
    .out_pixel   (pix),
    .write_enable(pix_we)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_data.fb_index      <= pos.fb_index;
      out_data.out_pixel     <= pix;
      out_data.write_enable  <= pix_we;
      out_data.source_offset <= pos.source_offset;
      out_data.last          <= pos.last;
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_data;

`ifndef SYNTHESIS
  // column counter stays inside the rectangle
  a_col_in_rect: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(col_count) < CMP_W'(cfg.rect_width))
    else $error("column counter beyond rectangle width");

  // register write restarts the raster
  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    write_en |=> (row_count == '0) && (col_count == '0))
    else $error("counters not cleared after configuration write");

  // final pixel of the rectangle wraps both counters
  a_last_wraps: assert property (@(posedge clk) disable iff (rst)
    item_take && col_end && row_end |=> (row_count == '0) && (col_count == '0))
    else $error("counters did not wrap after final pixel");

  // a full input register with a blocked result side refuses requests
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && !result.ready |-> !item.ready)
    else $error("request taken while pipeline is full");
`endif

endmodule

// ----- rtl/cpb_config.sv -----
// configuration register file with rectangle size saturation
module cpb_config #(
  parameter int MAX_DIM = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                write_en,
  input  cpb_pkg::reg_index_t                 reg_index,
  input  logic [cpb_pkg::CFG_DATA_W-1:0]      write_data,
  output cpb_pkg::cfg_t                       cfg
);
  import cpb_pkg::*;

  logic [COORD_W-1:0] v13;
  logic [COORD_W-1:0] dim_sat;

  assign v13 = write_data[COORD_W-1:0];

  // saturate a size to 1..MAX_DIM
  always_comb begin
    if (v13 == '0) begin
      dim_sat = COORD_W'(1);
    end else if (int'(v13) > MAX_DIM) begin
      dim_sat = COORD_W'(MAX_DIM);
    end else begin
      dim_sat = v13;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dest_x        <= DEST_X_RST;
      cfg.dest_y        <= DEST_Y_RST;
      cfg.rect_width    <= RECT_WIDTH_RST;
      cfg.rect_height   <= RECT_HEIGHT_RST;
      cfg.fb_width      <= FB_WIDTH_RST;
      cfg.fb_height     <= FB_HEIGHT_RST;
      cfg.fb_pitch      <= FB_PITCH_RST;
      cfg.source_stride <= STRIDE_RST;
    end else if (write_en) begin
      case (reg_index)
        REG_DEST_X:        cfg.dest_x        <= $signed(v13);
        REG_DEST_Y:        cfg.dest_y        <= $signed(v13);
        REG_RECT_WIDTH:    cfg.rect_width    <= dim_sat;
        REG_RECT_HEIGHT:   cfg.rect_height   <= dim_sat;
        REG_FB_WIDTH:      cfg.fb_width      <= v13;
        REG_FB_HEIGHT:     cfg.fb_height     <= v13;
        REG_FB_PITCH:      cfg.fb_pitch      <= write_data[PITCH_W-1:0];
        REG_SOURCE_STRIDE: cfg.source_stride <= write_data[PITCH_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- rtl/cpb_position.sv -----
// clip test, framebuffer index, source offset and last flag of one pixel
module cpb_position #(
  parameter int CNT_W = 12
) (
  input  cpb_pkg::cfg_t    cfg,
  input  logic [CNT_W-1:0] row,
  input  logic [CNT_W-1:0] col,
  output cpb_pkg::pos_t    pos
);
  import cpb_pkg::*;

  localparam int SUM_W = ((CNT_W > COORD_W) ? CNT_W : COORD_W) + 2;
  localparam int SO_W  = CNT_W + PITCH_W + 1;
  localparam int CMP_W = ((CNT_W + 1) > COORD_W) ? (CNT_W + 1) : COORD_W;
  localparam int FB_W  = COORD_W + PITCH_W;

  logic signed [SUM_W-1:0] px;
  logic signed [SUM_W-1:0] py;
  logic [FB_W-1:0]         fb_full;
  logic [SO_W-1:0]         so_full;

  assign px = SUM_W'(cfg.dest_x) + $signed(SUM_W'(col));
  assign py = SUM_W'(cfg.dest_y) + $signed(SUM_W'(row));

  // visible span is 0 <= coordinate < framebuffer size
  assign pos.visible = !px[SUM_W-1] && !py[SUM_W-1] &&
                       (px < $signed(SUM_W'(cfg.fb_width))) &&
                       (py < $signed(SUM_W'(cfg.fb_height)));

  // both coordinates fit 13 bits whenever visible
  assign fb_full = FB_W'(py[COORD_W-1:0]) * FB_W'(cfg.fb_pitch) + FB_W'(px[COORD_W-1:0]);
  assign pos.fb_index = pos.visible ? fb_full[IDX_W-1:0] : '0;

  assign so_full = SO_W'(row) * SO_W'(cfg.source_stride) + SO_W'(col);
  assign pos.source_offset = IDX_W'(so_full);

  assign pos.last = (CMP_W'(row) + CMP_W'(1) >= CMP_W'(cfg.rect_height)) &&
                    (CMP_W'(col) + CMP_W'(1) >= CMP_W'(cfg.rect_width));

endmodule

// ----- rtl/cpb_blend.sv -----
// premultiplied source-over blend of one pixel
module cpb_blend (
  input  logic [cpb_pkg::PIX_W-1:0] src_pixel,
  input  logic [cpb_pkg::PIX_W-1:0] dst_pixel,
  input  logic                      visible,
  output logic [cpb_pkg::PIX_W-1:0] out_pixel,
  output logic                      write_enable
);
  import cpb_pkg::*;

  logic [7:0]       alpha;
  logic [7:0]       inv_alpha;
  logic [8:0]       red;
  logic [8:0]       green;
  logic [8:0]       blue;
  logic [PIX_W-1:0] blended;

  // exact floor(x / 255) for 16-bit x whose quotient fits 8 bits
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] sum;
    sum = 17'(x) + 17'(x[15:8]) + 17'd1;
    return sum[15:8];
  endfunction

  // channel plus scaled destination, may reach 9 bits
  function automatic logic [8:0] mix(input logic [7:0] s, input logic [7:0] d,
                                     input logic [7:0] ia);
    logic [15:0] prod;
    prod = 16'(d) * 16'(ia);
    return 9'(s) + 9'(div255(prod));
  endfunction

  assign alpha     = src_pixel[ALPHA_LSB +: 8];
  assign inv_alpha = CHAN_MAX - alpha;

  assign red   = mix(src_pixel[23:16], dst_pixel[23:16], inv_alpha);
  assign green = mix(src_pixel[15:8], dst_pixel[15:8], inv_alpha);
  assign blue  = mix(src_pixel[7:0], dst_pixel[7:0], inv_alpha);

  // overflow spills into the next channel up
  assign blended = (PIX_W'(red) << 16) | (PIX_W'(green) << 8) | PIX_W'(blue);

  always_comb begin
    if (!visible) begin
      out_pixel    = '0;
      write_enable = 1'b0;
    end else if (alpha >= OPAQUE_ALPHA) begin
      out_pixel    = src_pixel;
      write_enable = 1'b1;
    end else if (alpha == '0) begin
      out_pixel    = dst_pixel;
      write_enable = 1'b0;
    end else begin
      out_pixel    = blended;
      write_enable = 1'b1;
    end
  end

endmodule
